FILE: rtl/lhtab_pkg.sv
// Shared widths, status codes and pool control types for the linear hash table.
package lhtab_pkg;

	localparam int KEY_W = 31;
	localparam int VAL_W = 32;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_NEGATIVE  = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	// commands to the overflow pool
	typedef struct packed {
		logic clear;
		logic scan;
		logic take;
		logic give;
	} pool_cmd_t;

	// scan result from the overflow pool
	typedef struct packed {
		logic done;
		logic hit;
	} pool_sts_t;

endpackage

FILE: rtl/linear_hash_table.sv
// Linear hash table top level: sequencer, bucket row memory and gather buffer.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  req     | req_valid, req_stall, kind/key/value | in
//  rsp     | rsp_valid, rsp_stall, status/...     | out
//  cfg     | cfg_valid, cfg_ready, cfg_data       | in
//
// A search or insert first finds its home bucket with the shared remainder unit, then
// walks the chain one bucket at a time; a negative key skips both. A new overflow
// bucket needs a scan of the pool. A split gathers every key of the chain into the
// gather buffer, rehashes it and reinserts it.
// After reset and after every cfg write a clearing pass over all MAX_BUCKETS +
// POOL_BUCKETS rows runs; no item is taken meanwhile. A result waits in the
// output register while rsp_stall is high; req is stalled until the item ends.
module linear_hash_table #(
	parameter int SLOTS        = 2,
	parameter int MAX_BUCKETS  = 256,
	parameter int POOL_BUCKETS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 kind,
	input  logic signed [31:0]   key,
	input  logic [31:0]          value,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [2:0]           status,
	output logic [31:0]          found_value,
	output logic [9:0]           stored_keys,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [8:0]           cfg_data
);
	import lhtab_pkg::*;

	localparam int NBUCK  = MAX_BUCKETS + POOL_BUCKETS;
	localparam int AW     = $clog2(NBUCK);
	localparam int AW1    = AW + 1;
	localparam int BCW    = $clog2(MAX_BUCKETS + 1);
	localparam int DW     = $clog2(2 * MAX_BUCKETS + 1);
	localparam int NSLOT  = NBUCK * SLOTS;
	localparam int KCW    = $clog2(NSLOT + 1);
	localparam int GATHER = (POOL_BUCKETS + 1) * SLOTS;
	localparam int GAW    = $clog2(GATHER);
	localparam int GNW    = $clog2(GATHER + 1);
	localparam int KSW    = $clog2(SLOTS + 1);
	localparam int SIW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PIW    = (POOL_BUCKETS > 1) ? $clog2(POOL_BUCKETS) : 1;
	localparam int PCW    = $clog2(POOL_BUCKETS + 1);
	localparam int KOFF   = SLOTS;
	localparam int VOFF   = SLOTS + SLOTS * KEY_W;
	localparam int LOFF   = SLOTS * (1 + KEY_W + VAL_W);
	localparam int RW     = LOFF + AW;
	localparam int GW     = KEY_W + VAL_W;

	typedef enum logic [18:0] {
		S_IDLE   = 19'b1 << 0,
		S_CLEAR  = 19'b1 << 1,
		S_HOME   = 19'b1 << 2,
		S_WALK   = 19'b1 << 3,
		S_DECIDE = 19'b1 << 4,
		S_PUT    = 19'b1 << 5,
		S_POOLW  = 19'b1 << 6,
		S_LINK2  = 19'b1 << 7,
		S_PLACED = 19'b1 << 8,
		S_SPLCHK = 19'b1 << 9,
		S_GATH   = 19'b1 << 10,
		S_GDIV   = 19'b1 << 11,
		S_GCHK   = 19'b1 << 12,
		S_CLRW   = 19'b1 << 13,
		S_SPLUPD = 19'b1 << 14,
		S_REIN   = 19'b1 << 15,
		S_REINRD = 19'b1 << 16,
		S_ROUND  = 19'b1 << 17,
		S_FIN    = 19'b1 << 18
	} state_t;

	state_t state_q;

	// table state
	logic [8:0]       init_q;
	logic [BCW-1:0]   bc_q;
	logic [BCW-1:0]   sp_q;
	logic [DW-1:0]    mod_q;
	logic [KCW-1:0]   kc_q;
	logic [AW-1:0]    clr_q;

	// item working registers
	logic             kind_q;
	logic             rein_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [AW-1:0]    cur_b_q;
	logic             free_q;
	logic [AW-1:0]    free_b_q;
	logic [SIW-1:0]   free_k_q;
	logic [RW-1:0]    free_row_q;
	logic [AW-1:0]    nb_q;
	status_t          st_q;
	logic [VAL_W-1:0] res_val_q;

	// split bookkeeping
	logic [KSW-1:0]   k_q;
	logic [GNW-1:0]   n_q;
	logic [GNW-1:0]   i_q;
	logic [PCW-1:0]   ov_q;
	logic             st_any_q, mv_any_q;
	logic [SIW-1:0]   st_rs_q, mv_rs_q;
	logic [GNW-1:0]   st_need_q, mv_need_q;

	// output register
	logic             rsp_valid_q;
	status_t          rsp_status_q;
	logic [31:0]      rsp_val_q;
	logic [9:0]       rsp_keys_q;

	// memories
	logic [RW-1:0]    rmem [NBUCK];
	logic [RW-1:0]    rd_q;
	logic [GW-1:0]    gmem [GATHER];
	logic [GW-1:0]    g_rd_q;

	logic             rd_en, wr_en, g_we, g_re;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic [RW-1:0]    wr_data;

	logic             div_start, div_done;
	logic [KEY_W-1:0] div_dvd;
	logic [DW-1:0]    div_rem;
	logic [DW-1:0]    m2;

	pool_cmd_t        pcmd;
	pool_sts_t        psts;
	logic [PIW-1:0]   scan_idx;
	logic [PCW-1:0]   free_cnt;

	logic             cfg_fire;
	logic [BCW-1:0]   base;

	logic             row_vld [SLOTS];
	logic [KEY_W-1:0] row_key [SLOTS];
	logic [VAL_W-1:0] row_val [SLOTS];
	logic [AW-1:0]    row_link, row_nxt;
	logic             hit, fr_any;
	logic [VAL_W-1:0] hit_val;
	logic [SIW-1:0]   fr_k;
	logic [SIW-1:0]   sk;
	logic             g_vld;
	logic [KEY_W-1:0] g_key;
	logic [VAL_W-1:0] g_val;
	logic [DW-1:0]    b1, bsel;
	logic [AW-1:0]    hb;
	logic             split_go, need_over, stay;
	logic [RW-1:0]    put_row, link_row, new_row;

	// a cfg write in idle wins over a waiting item, so the item is held off
	assign cfg_ready = (state_q == S_IDLE) || (state_q == S_CLEAR);
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign req_stall = (state_q != S_IDLE) || cfg_fire;
	assign m2        = mod_q << 1;

	// effective base bucket count
	always_comb begin
		if (init_q == '0) begin
			base = BCW'(1);
		end else if (32'(init_q) > 32'(MAX_BUCKETS)) begin
			base = BCW'(MAX_BUCKETS);
		end else begin
			base = BCW'(init_q);
		end
	end

	// decode of the row just read
	always_comb begin
		hit     = 1'b0;
		hit_val = '0;
		fr_any  = 1'b0;
		fr_k    = '0;
		for (int k = 0; k < SLOTS; k++) begin
			row_vld[k] = rd_q[k];
			row_key[k] = rd_q[KOFF + k * KEY_W +: KEY_W];
			row_val[k] = rd_q[VOFF + k * VAL_W +: VAL_W];
		end
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (row_vld[k] && row_key[k] == key_q) begin
				hit     = 1'b1;
				hit_val = row_val[k];
			end
			if (!row_vld[k]) begin
				fr_any = 1'b1;
				fr_k   = SIW'(k);
			end
		end
		row_link = rd_q[LOFF +: AW];
		row_nxt  = ({1'b0, row_link} < AW1'(NBUCK)) ? row_link : '0;
		sk       = k_q[SIW-1:0];
		g_vld    = rd_q[sk];
		g_key    = rd_q[KOFF + sk * KEY_W +: KEY_W];
		g_val    = rd_q[VOFF + sk * VAL_W +: VAL_W];
	end

	// home bucket from the remainder by twice the modulus
	always_comb begin
		b1   = (div_rem >= mod_q) ? div_rem - mod_q : div_rem;
		bsel = (b1 < DW'(sp_q)) ? div_rem : b1;
		hb   = (32'(bsel) >= 32'(MAX_BUCKETS)) ? '0 : AW'(bsel);
		stay = (div_rem == DW'(sp_q));
	end

	// split trigger and pool sufficiency
	always_comb begin
		split_go  = (bc_q < BCW'(MAX_BUCKETS)) &&
			(32'(kc_q) * 32'd4 >= 32'(bc_q) * 32'(3 * SLOTS));
		need_over = (32'(st_need_q) + 32'(mv_need_q)) > (32'(free_cnt) + 32'(ov_q));
	end

	// rows written back
	always_comb begin
		put_row = free_row_q;
		put_row[free_k_q] = 1'b1;
		put_row[KOFF + free_k_q * KEY_W +: KEY_W] = key_q;
		put_row[VOFF + free_k_q * VAL_W +: VAL_W] = val_q;
		link_row = rd_q;
		link_row[LOFF +: AW] = AW'(MAX_BUCKETS) + AW'(scan_idx);
		new_row = '0;
		new_row[0] = 1'b1;
		new_row[KOFF +: KEY_W] = key_q;
		new_row[VOFF +: VAL_W] = val_q;
	end

	// memory, divider and pool control
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = '0;
		g_we      = 1'b0;
		g_re      = 1'b0;
		div_start = 1'b0;
		div_dvd   = g_rd_q[GW-1 -: KEY_W];
		pcmd      = '0;
		pcmd.clear = cfg_fire;
		unique case (state_q)
			S_IDLE: begin
				div_dvd   = key[KEY_W-1:0];
				div_start = req_valid && !key[31] && !cfg_fire;
			end
			S_CLEAR: begin
				wr_en   = !cfg_fire;
				wr_addr = clr_q;
			end
			S_HOME: begin
				rd_en   = div_done;
				rd_addr = hb;
			end
			S_WALK: begin
				rd_en   = !(hit && !rein_q) && (row_nxt != '0);
				rd_addr = row_nxt;
			end
			S_DECIDE: begin
				pcmd.scan = !free_q;
			end
			S_PUT: begin
				wr_en   = 1'b1;
				wr_addr = free_b_q;
				wr_data = put_row;
			end
			S_POOLW: begin
				wr_en     = psts.done && psts.hit;
				wr_addr   = cur_b_q;
				wr_data   = link_row;
				pcmd.take = psts.done && psts.hit;
			end
			S_LINK2: begin
				wr_en   = 1'b1;
				wr_addr = nb_q;
				wr_data = new_row;
			end
			S_SPLCHK: begin
				rd_en   = split_go && (sp_q < BCW'(MAX_BUCKETS));
				rd_addr = AW'(sp_q);
			end
			S_GATH: begin
				div_dvd = g_key;
				if (k_q == KSW'(SLOTS)) begin
					rd_en   = (row_nxt != '0);
					rd_addr = row_nxt;
				end else begin
					g_we      = g_vld;
					div_start = g_vld;
				end
			end
			S_GCHK: begin
				rd_en   = !need_over;
				rd_addr = AW'(sp_q);
			end
			S_CLRW: begin
				wr_en     = 1'b1;
				wr_addr   = cur_b_q;
				pcmd.give = (32'(cur_b_q) >= 32'(MAX_BUCKETS));
				rd_en     = (row_nxt != '0);
				rd_addr   = row_nxt;
			end
			S_REIN: begin
				g_re = (i_q != n_q);
			end
			S_REINRD: begin
				div_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// bucket row memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rmem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= rmem[rd_addr];
		end
	end

	// gather buffer for the chain being split
	always_ff @(posedge clk) begin
		if (g_we) begin
			gmem[n_q[GAW-1:0]] <= {g_key, g_val};
		end
		if (g_re) begin
			g_rd_q <= gmem[i_q[GAW-1:0]];
		end
	end

	lhtab_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (m2),
		.done     (div_done),
		.rem      (div_rem)
	);

	lhtab_pool #(.POOL_BUCKETS(POOL_BUCKETS), .PIW(PIW), .PCW(PCW)) u_pool (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (pcmd),
		.give_idx (PIW'(cur_b_q - AW'(MAX_BUCKETS))),
		.sts      (psts),
		.scan_idx (scan_idx),
		.free_cnt (free_cnt)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			init_q       <= 9'd4;
			bc_q         <= '0;
			sp_q         <= '0;
			mod_q        <= '0;
			kc_q         <= '0;
			clr_q        <= '0;
			kind_q       <= KIND_INSERT;
			rein_q       <= 1'b0;
			key_q        <= '0;
			val_q        <= '0;
			cur_b_q      <= '0;
			free_q       <= 1'b0;
			free_b_q     <= '0;
			free_k_q     <= '0;
			free_row_q   <= '0;
			nb_q         <= '0;
			st_q         <= ST_INSERTED;
			res_val_q    <= '0;
			k_q          <= '0;
			n_q          <= '0;
			i_q          <= '0;
			ov_q         <= '0;
			st_any_q     <= 1'b0;
			mv_any_q     <= 1'b0;
			st_rs_q      <= '0;
			mv_rs_q      <= '0;
			st_need_q    <= '0;
			mv_need_q    <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_INSERTED;
			rsp_val_q    <= '0;
			rsp_keys_q   <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_fire) begin
				init_q  <= cfg_data;
				clr_q   <= '0;
				state_q <= S_CLEAR;
			end else begin
				unique case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == AW'(NBUCK - 1)) begin
							bc_q    <= base;
							mod_q   <= DW'(base);
							sp_q    <= '0;
							kc_q    <= '0;
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (req_valid) begin
							kind_q    <= kind;
							key_q     <= key[KEY_W-1:0];
							val_q     <= value;
							rein_q    <= 1'b0;
							res_val_q <= '0;
							if (key[31]) begin
								st_q    <= ST_NEGATIVE;
								state_q <= S_FIN;
							end else begin
								state_q <= S_HOME;
							end
						end
					end
					S_HOME: begin
						if (div_done) begin
							cur_b_q <= hb;
							free_q  <= 1'b0;
							state_q <= S_WALK;
						end
					end
					// one bucket of the chain per cycle
					S_WALK: begin
						if (hit && !rein_q) begin
							if (kind_q == KIND_SEARCH) begin
								st_q      <= ST_FOUND;
								res_val_q <= hit_val;
							end else begin
								st_q <= ST_DUPLICATE;
							end
							state_q <= S_FIN;
						end else begin
							if (!free_q && fr_any) begin
								free_q     <= 1'b1;
								free_b_q   <= cur_b_q;
								free_k_q   <= fr_k;
								free_row_q <= rd_q;
							end
							if (row_nxt == '0) begin
								if (!rein_q && kind_q == KIND_SEARCH) begin
									st_q    <= ST_NOT_FOUND;
									state_q <= S_FIN;
								end else begin
									state_q <= S_DECIDE;
								end
							end else begin
								cur_b_q <= row_nxt;
							end
						end
					end
					S_DECIDE: begin
						state_q <= free_q ? S_PUT : S_POOLW;
					end
					S_PUT: begin
						state_q <= S_PLACED;
					end
					S_POOLW: begin
						if (psts.done) begin
							if (psts.hit) begin
								nb_q    <= AW'(MAX_BUCKETS) + AW'(scan_idx);
								state_q <= S_LINK2;
							end else if (rein_q) begin
								i_q     <= i_q + 1'b1;
								state_q <= S_REIN;
							end else begin
								st_q    <= ST_FULL;
								state_q <= S_FIN;
							end
						end
					end
					S_LINK2: begin
						state_q <= S_PLACED;
					end
					S_PLACED: begin
						if (rein_q) begin
							i_q     <= i_q + 1'b1;
							state_q <= S_REIN;
						end else begin
							kc_q    <= kc_q + 1'b1;
							st_q    <= ST_INSERTED;
							state_q <= S_SPLCHK;
						end
					end
					S_SPLCHK: begin
						if (split_go && (sp_q < BCW'(MAX_BUCKETS))) begin
							cur_b_q   <= AW'(sp_q);
							k_q       <= '0;
							n_q       <= '0;
							ov_q      <= '0;
							st_any_q  <= 1'b0;
							mv_any_q  <= 1'b0;
							st_rs_q   <= '0;
							mv_rs_q   <= '0;
							st_need_q <= '0;
							mv_need_q <= '0;
							state_q   <= S_GATH;
						end else begin
							state_q <= S_FIN;
						end
					end
					// collect the chain, one slot per visit
					S_GATH: begin
						if (k_q == KSW'(SLOTS)) begin
							if (row_nxt == '0) begin
								state_q <= S_GCHK;
							end else begin
								ov_q    <= ov_q + 1'b1;
								cur_b_q <= row_nxt;
								k_q     <= '0;
							end
						end else if (g_vld) begin
							state_q <= S_GDIV;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
					// overflow need grows at each count past a multiple of SLOTS
					S_GDIV: begin
						if (div_done) begin
							if (stay) begin
								if (st_any_q && st_rs_q == '0) begin
									st_need_q <= st_need_q + 1'b1;
								end
								st_rs_q  <= (st_rs_q == SIW'(SLOTS - 1)) ? '0 : st_rs_q + 1'b1;
								st_any_q <= 1'b1;
							end else begin
								if (mv_any_q && mv_rs_q == '0) begin
									mv_need_q <= mv_need_q + 1'b1;
								end
								mv_rs_q  <= (mv_rs_q == SIW'(SLOTS - 1)) ? '0 : mv_rs_q + 1'b1;
								mv_any_q <= 1'b1;
							end
							n_q     <= n_q + 1'b1;
							k_q     <= k_q + 1'b1;
							state_q <= S_GATH;
						end
					end
					S_GCHK: begin
						if (need_over) begin
							state_q <= S_FIN;
						end else begin
							cur_b_q <= AW'(sp_q);
							state_q <= S_CLRW;
						end
					end
					// empty the chain and hand its overflow buckets back
					S_CLRW: begin
						if (row_nxt == '0) begin
							state_q <= S_SPLUPD;
						end else begin
							cur_b_q <= row_nxt;
						end
					end
					S_SPLUPD: begin
						bc_q    <= bc_q + 1'b1;
						sp_q    <= sp_q + 1'b1;
						i_q     <= '0;
						state_q <= S_REIN;
					end
					S_REIN: begin
						state_q <= (i_q == n_q) ? S_ROUND : S_REINRD;
					end
					S_REINRD: begin
						key_q   <= g_rd_q[GW-1 -: KEY_W];
						val_q   <= g_rd_q[VAL_W-1:0];
						rein_q  <= 1'b1;
						state_q <= S_HOME;
					end
					S_ROUND: begin
						if (DW'(bc_q) == m2) begin
							mod_q <= m2;
							sp_q  <= '0;
						end
						rein_q  <= 1'b0;
						state_q <= S_SPLCHK;
					end
					S_FIN: begin
						if (!rsp_valid_q || !rsp_stall) begin
							rsp_valid_q  <= 1'b1;
							rsp_status_q <= st_q;
							rsp_val_q    <= res_val_q;
							rsp_keys_q   <= 10'(kc_q);
							state_q      <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_status_q;
	assign found_value = rsp_val_q;
	assign stored_keys = rsp_keys_q;

endmodule

FILE: rtl/lhtab_div.sv
// Shared bit-serial remainder unit: key modulo a bucket modulus.
module lhtab_div #(
	parameter int DW = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lhtab_pkg::KEY_W-1:0] dividend,
	input  logic [DW-1:0]               divisor,
	output logic                        done,
	output logic [DW-1:0]               rem
);
	import lhtab_pkg::*;

	localparam int CW = $clog2(KEY_W + 1);

	logic [KEY_W-1:0] dvd_q;
	logic [DW-1:0]    dsr_q;
	logic [DW-1:0]    rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;

	// one quotient bit per cycle, restoring form
	always_comb begin
		trial = {rem_q, dvd_q[KEY_W-1]};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q  <= dividend;
				dsr_q  <= divisor;
				rem_q  <= '0;
				cnt_q  <= CW'(KEY_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				dvd_q <= dvd_q << 1;
				if (trial >= {1'b0, dsr_q}) begin
					rem_q <= diff[DW-1:0];
				end else begin
					rem_q <= trial[DW-1:0];
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/lhtab_pool.sv
// Overflow bucket pool: free map, free count and a first-free scanner.
module lhtab_pool #(
	parameter int POOL_BUCKETS = 64,
	parameter int PIW = 6,
	parameter int PCW = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lhtab_pkg::pool_cmd_t  cmd,
	input  logic [PIW-1:0]        give_idx,
	output lhtab_pkg::pool_sts_t  sts,
	output logic [PIW-1:0]        scan_idx,
	output logic [PCW-1:0]        free_cnt
);
	import lhtab_pkg::*;

	logic [POOL_BUCKETS-1:0] free_q;
	logic [PCW-1:0]          cnt_q;
	logic [PIW-1:0]          idx_q;
	logic                    busy_q;
	pool_sts_t               sts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			cnt_q  <= PCW'(POOL_BUCKETS);
			idx_q  <= '0;
			busy_q <= 1'b0;
			sts_q  <= '0;
		end else begin
			sts_q <= '0;
			if (cmd.clear) begin
				free_q <= '1;
				cnt_q  <= PCW'(POOL_BUCKETS);
				busy_q <= 1'b0;
			end else begin
				// scan one entry per cycle from the bottom
				if (cmd.scan) begin
					idx_q  <= '0;
					busy_q <= 1'b1;
				end else if (busy_q) begin
					if (free_q[idx_q]) begin
						busy_q   <= 1'b0;
						sts_q    <= '{done: 1'b1, hit: 1'b1};
					end else if (idx_q == PIW'(POOL_BUCKETS - 1)) begin
						busy_q   <= 1'b0;
						sts_q    <= '{done: 1'b1, hit: 1'b0};
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				if (cmd.take) begin
					free_q[idx_q] <= 1'b0;
					cnt_q         <= cnt_q - 1'b1;
				end else if (cmd.give) begin
					free_q[give_idx] <= 1'b1;
					cnt_q            <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign sts      = sts_q;
	assign scan_idx = idx_q;
	assign free_cnt = cnt_q;

endmodule

FILE: bench/tb_linear_hash_table.sv
// Testbench for the linear hash table: predictor, stimulus tasks and result checker.
`timescale 1ns / 1ps

module tb_linear_hash_table;
	import lhtab_pkg::*;

	localparam int SLOTS = 2;
	localparam int MAX_BUCKETS = 256;
	localparam int POOL_BUCKETS = 64;
	localparam int NBUCK = MAX_BUCKETS + POOL_BUCKETS;
	localparam int NSLOT = NBUCK * SLOTS;
	localparam int GATHER = (POOL_BUCKETS + 1) * SLOTS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic kind = KIND_INSERT;
	logic signed [31:0] key = '0;
	logic [31:0] value = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [2:0] status;
	logic [31:0] found_value;
	logic [9:0] stored_keys;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [8:0] cfg_data = '0;

	linear_hash_table #(.SLOTS(SLOTS), .MAX_BUCKETS(MAX_BUCKETS),
		.POOL_BUCKETS(POOL_BUCKETS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.kind(kind), .key(key), .value(value),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .found_value(found_value), .stored_keys(stored_keys),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// shadow table
	logic [8:0] shadow_base_reg;
	bit tv_valid [NSLOT];
	logic [31:0] tv_key [NSLOT];
	logic [31:0] tv_val [NSLOT];
	int unsigned tv_link [NBUCK];
	bit tv_pool [POOL_BUCKETS];
	int unsigned tv_round, tv_ptr, tv_buckets, tv_keys;
	logic [31:0] g_key [GATHER];
	logic [31:0] g_val [GATHER];

	typedef struct packed {
		logic [2:0] st;
		logic [31:0] fv;
		logic [9:0] nk;
	} hash_result_t;

	hash_result_t pending_results[$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;

	function automatic int unsigned eff_base();
		int unsigned v;
		v = shadow_base_reg;
		if (v == 0) v = 1;
		if (v > MAX_BUCKETS) v = MAX_BUCKETS;
		return v;
	endfunction

	function automatic void table_clear();
		for (int i = 0; i < NSLOT; i++) begin
			tv_valid[i] = 0;
			tv_key[i] = '0;
			tv_val[i] = '0;
		end
		for (int i = 0; i < NBUCK; i++) tv_link[i] = 0;
		for (int i = 0; i < POOL_BUCKETS; i++) tv_pool[i] = 1;
		tv_round = 0;
		tv_ptr = 0;
		tv_buckets = eff_base();
		tv_keys = 0;
	endfunction

	function automatic int unsigned bucket_of(logic [31:0] k);
		longint unsigned m, b;
		m = longint'(eff_base()) << (tv_round & 31);
		b = longint'(k) % m;
		if (b < tv_ptr) b = longint'(k) % (m << 1);
		if (b >= MAX_BUCKETS) b = 0;
		return int'(b);
	endfunction

	function automatic int unsigned link_of(int unsigned b);
		return (tv_link[b] < NBUCK) ? tv_link[b] : 0;
	endfunction

	function automatic int lookup(int unsigned bkt, logic [31:0] k);
		int unsigned b;
		b = bkt;
		for (int step = 0; step < NBUCK; step++) begin
			for (int s = 0; s < SLOTS; s++)
				if (tv_valid[b*SLOTS+s] && tv_key[b*SLOTS+s] == k) return b*SLOTS+s;
			b = link_of(b);
			if (b == 0) break;
		end
		return -1;
	endfunction

	function automatic bit store_entry(int unsigned bkt, logic [31:0] k, logic [31:0] v);
		int unsigned b, last, nb;
		b = bkt;
		last = bkt;
		for (int step = 0; step < NBUCK; step++) begin
			for (int s = 0; s < SLOTS; s++)
				if (!tv_valid[b*SLOTS+s]) begin
					tv_valid[b*SLOTS+s] = 1;
					tv_key[b*SLOTS+s] = k;
					tv_val[b*SLOTS+s] = v;
					return 1;
				end
			last = b;
			b = link_of(b);
			if (b == 0) break;
		end
		for (int p = 0; p < POOL_BUCKETS; p++)
			if (tv_pool[p]) begin
				nb = MAX_BUCKETS + p;
				tv_pool[p] = 0;
				tv_link[last] = nb;
				tv_link[nb] = 0;
				tv_valid[nb*SLOTS] = 1;
				tv_key[nb*SLOTS] = k;
				tv_val[nb*SLOTS] = v;
				return 1;
			end
		return 0;
	endfunction

	function automatic int unsigned extra_need(int unsigned n);
		return (n == 0) ? 0 : (n - 1) / SLOTS;
	endfunction

	function automatic bit split_bucket();
		int unsigned s, n, n_stay, ov, nfree, b, nx;
		longint unsigned m2;
		s = tv_ptr;
		m2 = (longint'(eff_base()) << (tv_round & 31)) << 1;
		n = 0; n_stay = 0; ov = 0; nfree = 0;
		if (s >= MAX_BUCKETS) return 0;
		// gather the chain
		b = s;
		for (int step = 0; step < NBUCK; step++) begin
			for (int j = 0; j < SLOTS; j++)
				if (tv_valid[b*SLOTS+j] && n < GATHER) begin
					g_key[n] = tv_key[b*SLOTS+j];
					g_val[n] = tv_val[b*SLOTS+j];
					if (longint'(tv_key[b*SLOTS+j]) % m2 == s) n_stay++;
					n++;
				end
			b = link_of(b);
			if (b == 0) break;
			ov++;
		end
		for (int p = 0; p < POOL_BUCKETS; p++) if (tv_pool[p]) nfree++;
		if (extra_need(n_stay) + extra_need(n - n_stay) > nfree + ov) return 0;
		// release the chain
		b = s;
		for (int step = 0; step < NBUCK; step++) begin
			nx = link_of(b);
			for (int j = 0; j < SLOTS; j++) tv_valid[b*SLOTS+j] = 0;
			tv_link[b] = 0;
			if (b >= MAX_BUCKETS) tv_pool[b-MAX_BUCKETS] = 1;
			if (nx == 0) break;
			b = nx;
		end
		tv_buckets++;
		tv_ptr++;
		for (int i = 0; i < n; i++) void'(store_entry(bucket_of(g_key[i]), g_key[i], g_val[i]));
		if (longint'(tv_buckets) == m2) begin
			tv_round++;
			tv_ptr = 0;
		end
		return 1;
	endfunction

	function automatic hash_result_t predict_lookup(logic k_kind, logic [31:0] k, logic [31:0] v);
		hash_result_t r;
		int hit;
		int unsigned hb;
		r.fv = '0;
		if (k[31]) begin
			r.st = ST_NEGATIVE;
		end else if (k_kind == KIND_SEARCH) begin
			hit = lookup(bucket_of(k), k);
			if (hit >= 0) begin
				r.st = ST_FOUND;
				r.fv = tv_val[hit];
			end else begin
				r.st = ST_NOT_FOUND;
			end
		end else begin
			hb = bucket_of(k);
			if (lookup(hb, k) >= 0) begin
				r.st = ST_DUPLICATE;
			end else if (!store_entry(hb, k, v)) begin
				r.st = ST_FULL;
			end else begin
				r.st = ST_INSERTED;
				tv_keys++;
				while (tv_buckets < MAX_BUCKETS &&
						4 * longint'(tv_keys) >= 3 * longint'(tv_buckets) * SLOTS) begin
					if (!split_bucket()) break;
				end
			end
		end
		r.nk = tv_keys[9:0];
		return r;
	endfunction

	// send one item, predict at acceptance; valid drops only while idling
	task automatic send_item(logic k_kind, logic [31:0] k, logic [31:0] v);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		kind <= k_kind;
		key <= k;
		value <= v;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_results.push_back(predict_lookup(k_kind, k, v));
		items_sent++;
	endtask

	// receiver stall pattern, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		hash_result_t exp_r;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: status %0d", status);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.st) begin
					$error("status expected %0d actual %0d", exp_r.st, status);
					errors++;
				end
				if (found_value !== exp_r.fv) begin
					$error("found_value expected %0h actual %0h", exp_r.fv, found_value);
					errors++;
				end
				if (stored_keys !== exp_r.nk) begin
					$error("stored_keys expected %0d actual %0d", exp_r.nk, stored_keys);
					errors++;
				end
			end
		end
	end

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_base(logic [8:0] d);
		drain();
		cfg_data <= d;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		shadow_base_reg = d;
		table_clear();
	endtask

	function automatic logic [31:0] rand_key(int unsigned span);
		return $urandom_range(span);
	endfunction

	task automatic test_directed();
		send_item(KIND_SEARCH, 32'd5, 32'd0);
		send_item(KIND_INSERT, 32'd0, 32'hFFFF_FFFF);
		send_item(KIND_INSERT, 32'h7FFF_FFFF, 32'h0);
		send_item(KIND_INSERT, 32'h8000_0000, 32'h1234);
		send_item(KIND_SEARCH, 32'hFFFF_FFFF, 32'h0);
		send_item(KIND_SEARCH, 32'd0, 32'h5555_AAAA);
		send_item(KIND_SEARCH, 32'h7FFF_FFFF, 32'h0);
		send_item(KIND_INSERT, 32'd0, 32'h1);
		send_item(KIND_SEARCH, 32'd0, 32'h0);
		for (int i = 1; i <= 12; i++) send_item(KIND_INSERT, i * 4, 32'hA000_0000 | i);
		send_item(KIND_SEARCH, 32'd8, 32'h0);
		send_item(KIND_SEARCH, 32'd44, 32'h0);
	endtask

	// keys all landing in bucket 0 with base 1 keep chains long and fill the pool
	task automatic test_pool_full();
		write_base(9'd0);
		for (int i = 0; i < 160; i++) send_item(KIND_INSERT, i * 256 * 64, $urandom());
		send_item(KIND_SEARCH, 32'd0, 32'h0);
	endtask

	task automatic test_random(int n, int unsigned span);
		logic [31:0] k;
		for (int i = 0; i < n; i++) begin
			k = rand_key(span);
			case ($urandom_range(9))
				0: k = $urandom();
				1: k = k | 32'h8000_0000;
				2: k = $urandom() & 32'h7FFF_FFFF;
				default: ;
			endcase
			send_item($urandom_range(99) < 60 ? KIND_INSERT : KIND_SEARCH, k, $urandom());
		end
	endtask

	// long receiver hold-off while items keep coming
	task automatic test_backpressure();
		hold_cycles = 3000;
		for (int i = 0; i < 20; i++) send_item(KIND_INSERT, rand_key(2000), $urandom());
	endtask

	initial begin
		shadow_base_reg = 9'd4;
		table_clear();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 10;
		recv_idle_pct = 67;
		test_directed();
		test_random(100, 300);
		write_base(9'd256);
		test_random(100, 4000);
		send_idle_pct = 67;
		recv_idle_pct = 10;
		write_base(9'd511);
		test_random(80, 1000);
		write_base(9'd1);
		test_backpressure();
		test_random(100, 200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_pool_full();
		write_base(9'd3);
		test_random(100, 500);
		drain();
		$display("Covered %0d items and %0d results over base sizes 0, 1, 3, 4, 256, 511.",
			items_sent, results_seen);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#300ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
